FILE: rtl/piecewise_linear_width_lookup_assert.svh
// assertion macros for the width lookup checker
`ifndef PIECEWISE_LINEAR_WIDTH_LOOKUP_ASSERT_SVH
`define PIECEWISE_LINEAR_WIDTH_LOOKUP_ASSERT_SVH
// implication checked every clock outside reset
`define PLW_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define PLW_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

FILE: rtl/plw_pkg.sv
// shared types and constants for the width lookup
`default_nettype none
package plw_pkg;
    localparam int MAX_POINTS = 16;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_EVAL   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NEG      = 2'd1;
    localparam logic [1:0] ST_ORDER    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] station;
        logic signed [23:0] left_w;
        logic signed [23:0] right_w;
    } t_cmd;
    typedef struct packed {
        logic [22:0] left_w;
        logic [22:0] right_w;
        logic [1:0]  status;
    } t_res;
endpackage
`default_nettype wire

FILE: rtl/piecewise_linear_width_lookup.sv
// top level: breakpoint width lookup with interpolation
// clear, append, empty evaluate and unused mode answer from idle; other evaluates
// clamp low or high at the table ends, or scan segments upward and interpolate
// the engine holds one item at a time: it takes no new item until its result is taken
// the 56-step serial divider is run twice per interpolation
// reset: synchronous active low, empties queue and table count
`default_nettype none
module piecewise_linear_width_lookup (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [79:0]  s_axis_tdata,  // station_pos, left_in, right_in
    input  wire  [1:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [47:0]  m_axis_tdata   // left_width, right_width, status
);
    import plw_pkg::*;
    t_cmd in_cmd, q_cmd;
    t_res res;
    logic q_valid, q_ready;
    // unpack the stream word into a command
    assign in_cmd.mode    = s_axis_tuser;
    assign in_cmd.station = s_axis_tdata[31:0];
    assign in_cmd.left_w  = s_axis_tdata[55:32];
    assign in_cmd.right_w = s_axis_tdata[79:56];
    plw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_cmd(in_cmd), .o_valid(q_valid),
        .i_ready(q_ready), .o_cmd(q_cmd)
    );
    plw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_cmd(q_cmd), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );
    assign m_axis_tdata = {res.status, res.right_w, res.left_w};
endmodule
`default_nettype wire

FILE: rtl/plw_front.sv
// command queue between input side and engine
`default_nettype none
module plw_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  plw_pkg::t_cmd       i_cmd,
    output logic                o_valid,
    input  wire                 i_ready,
    output plw_pkg::t_cmd       o_cmd
);
    import plw_pkg::*;
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/plw_div.sv
// serial signed divider, quotient truncated toward zero
`default_nettype none
module plw_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire signed [55:0]   i_num,
    input  wire        [31:0]   i_den,
    output logic                o_done,
    output logic signed [55:0]  o_quo
);
    logic [55:0] r_q;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg;
    logic [32:0] trial;
    logic [32:0] shifted;
    assign shifted = {r_rem[31:0], r_q[55]};
    assign trial = shifted - {1'b0, i_den};
    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0; r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd55) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_neg <= i_num[55];
            r_q   <= i_num[55] ? -i_num : i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!trial[32]) begin
                r_rem <= trial;
                r_q   <= {r_q[54:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_q   <= {r_q[54:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/plw_back.sv
// table store, segment search and interpolation sequencer
`default_nettype none
module plw_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  plw_pkg::t_cmd       i_cmd,
    output logic                o_valid,
    input  wire                 i_ready,
    output plw_pkg::t_res       o_res
);
    import plw_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_FIRST, S_LAST, S_SCAN, S_HI, S_MUL, S_DIV, S_OUT}
        t_state;
    t_state r_state;
    logic [79:0] r_mem [MAX_POINTS];
    logic [79:0] r_rd;
    logic [IDX_W-1:0] r_addr;
    logic [CNT_W-1:0] r_count;
    t_cmd r_cmd;
    logic signed [31:0] r_last_st, r_ls;
    logic signed [23:0] r_ll, r_lr;
    logic signed [31:0] r_span;
    logic signed [55:0] r_nl, r_nr;
    logic signed [32:0] r_ds;
    logic signed [24:0] r_dl, r_dr;
    logic r_side;
    logic r_start;
    logic signed [55:0] div_num;
    logic div_done;
    logic signed [55:0] div_q;
    logic [22:0] r_lo_res;
    logic signed [31:0] rd_st;
    logic signed [23:0] rd_l, rd_r;
    logic signed [55:0] sum;
    assign rd_st = r_rd[79:48];
    assign rd_l  = r_rd[47:24];
    assign rd_r  = r_rd[23:0];
    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign div_num = r_side ? r_nr : r_nl;
    assign sum = div_q + (r_side ? 56'(r_lr) : 56'(r_ll));
    plw_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_num(div_num),
        .i_den(r_span), .o_done(div_done), .o_quo(div_q)
    );
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr];
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; o_valid <= 1'b0; r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.mode)
                            MODE_CLEAR: begin
                                r_count <= '0; o_res <= '0; o_valid <= 1'b1;
                            end
                            MODE_APPEND: begin
                                o_valid <= 1'b1;
                                if (i_cmd.station < 0 || i_cmd.left_w < 0 ||
                                    i_cmd.right_w < 0) begin
                                    o_res <= '{left_w: '0, right_w: '0, status: ST_NEG};
                                end else if (r_count != '0 &&
                                             i_cmd.station <= r_last_st) begin
                                    o_res <= '{left_w: '0, right_w: '0, status: ST_ORDER};
                                end else if (r_count == CNT_W'(MAX_POINTS)) begin
                                    o_res <= '{left_w: '0, right_w: '0, status: ST_FULL};
                                end else begin
                                    o_res <= '0;
                                    r_mem[r_count[IDX_W-1:0]] <= {i_cmd.station,
                                        i_cmd.left_w, i_cmd.right_w};
                                    r_last_st <= i_cmd.station;
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            MODE_EVAL: begin
                                if (r_count == '0) begin
                                    o_res <= '0;
                                    o_valid <= 1'b1;
                                end else begin
                                    r_addr  <= '0;
                                    r_state <= S_FIRST;
                                end
                            end
                            default: begin
                                o_res <= '0; o_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_FIRST: begin
                    // data for entry 0 arrives next cycle
                    r_addr  <= IDX_W'(r_count - 1'b1);
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    if (r_cmd.station <= rd_st) begin
                        o_res <= '{left_w: rd_l[22:0], right_w: rd_r[22:0], status: ST_OK};
                        o_valid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_ls <= rd_st; r_ll <= rd_l; r_lr <= rd_r;
                        r_addr <= IDX_W'(1); r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // rd holds last entry first time, then walks upward
                    if (r_cmd.station >= r_last_st && r_addr == IDX_W'(1)
                        && rd_st == r_last_st) begin
                        o_res <= '{left_w: rd_l[22:0], right_w: rd_r[22:0], status: ST_OK};
                        o_valid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_state <= S_HI;
                    end
                end
                S_HI: begin
                    if (r_cmd.station < rd_st) begin
                        r_span <= rd_st - r_ls;
                        r_ds <= 33'(r_cmd.station) - 33'(r_ls);
                        r_dl <= 25'(rd_l) - 25'(r_ll);
                        r_dr <= 25'(rd_r) - 25'(r_lr);
                        r_state <= S_MUL;
                    end else begin
                        r_ls <= rd_st; r_ll <= rd_l; r_lr <= rd_r;
                        r_addr <= r_addr + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_MUL: begin
                    r_nl <= 56'(r_ds * r_dl);
                    r_nr <= 56'(r_ds * r_dr);
                    r_side <= 1'b0; r_start <= 1'b1; r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (!r_side) begin
                            r_lo_res <= sum[22:0];
                            r_side <= 1'b1; r_start <= 1'b1;
                        end else begin
                            o_res <= '{left_w: r_lo_res, right_w: sum[22:0], status: ST_OK};
                            o_valid <= 1'b1; r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/plw_checker.sv
// port-level checker for the width lookup
`default_nettype none
`include "piecewise_linear_width_lookup_assert.svh"
module plw_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire [1:0]   s_axis_tuser,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [47:0]  m_axis_tdata
);
    import plw_pkg::*;
    logic out_stall, in_stall, out_err;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign in_stall  = s_axis_tvalid && !s_axis_tready;
    assign out_err   = m_axis_tvalid && (m_axis_tdata[47:46] != ST_OK);
    `PLW_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `PLW_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, out_err, m_axis_tdata[45:0] == 46'd0)
    `PLW_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, in_stall, s_axis_tvalid && $stable(s_axis_tuser))
endmodule
bind piecewise_linear_width_lookup plw_checker u_plw_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_piecewise_linear_width_lookup.sv
// testbench for the piecewise linear width lookup: directed and random items, self-checked
`default_nettype none
module tb_piecewise_linear_width_lookup;
    timeunit 1ns;
    timeprecision 1ps;
    import plw_pkg::*;

    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] station;
        logic signed [23:0] left_w;
        logic signed [23:0] right_w;
    } lookup_item_t;

    typedef struct {
        logic [22:0] left_w;
        logic [22:0] right_w;
        logic [1:0]  status;
    } width_result_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;   // station_pos, left_in, right_in
    logic [1:0]   s_axis_tuser;   // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;   // left_width, right_width, status

    piecewise_linear_width_lookup uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predictor's own copy of the breakpoint table
    longint        bp_station [MAX_POINTS];
    longint        bp_left [MAX_POINTS];
    longint        bp_right [MAX_POINTS];
    int            bp_count;

    lookup_item_t  pending_items[$];
    width_result_t expected_widths[$];
    int            mismatch_count;
    int            results_seen;
    int            sender_idle_pct;
    int            receiver_stall_pct;
    longint        cycle_count;
    bit            stim_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint interpolate(longint s, longint ls, longint hs,
                                           longint lw, longint hw);
        longint num;
        num = (s - ls) * (hw - lw);
        return lw + num / (hs - ls);   // sv division truncates toward zero
    endfunction

    // advance the predictor by one accepted item
    function automatic width_result_t predict_widths(lookup_item_t it);
        width_result_t r;
        longint s, lw, rw, lo, ro;
        int k;
        s = it.station;
        lw = it.left_w;
        rw = it.right_w;
        lo = 0;
        ro = 0;
        r.status = ST_OK;
        if (it.mode == MODE_CLEAR) begin
            bp_count = 0;
        end else if (it.mode == MODE_APPEND) begin
            if (s < 0 || lw < 0 || rw < 0) begin
                r.status = ST_NEG;
            end else if (bp_count > 0 && s <= bp_station[bp_count-1]) begin
                r.status = ST_ORDER;
            end else if (bp_count >= MAX_POINTS) begin
                r.status = ST_FULL;
            end else begin
                bp_station[bp_count] = s;
                bp_left[bp_count] = lw;
                bp_right[bp_count] = rw;
                bp_count++;
            end
        end else if (it.mode == MODE_EVAL && bp_count > 0) begin
            if (s <= bp_station[0]) begin
                lo = bp_left[0];
                ro = bp_right[0];
            end else if (s >= bp_station[bp_count-1]) begin
                lo = bp_left[bp_count-1];
                ro = bp_right[bp_count-1];
            end else begin
                // first entry whose station lies above the query
                k = 1;
                while (k < bp_count - 1 && !(s < bp_station[k])) k++;
                lo = interpolate(s, bp_station[k-1], bp_station[k], bp_left[k-1], bp_left[k]);
                ro = interpolate(s, bp_station[k-1], bp_station[k],
                                 bp_right[k-1], bp_right[k]);
            end
        end
        r.left_w = lo[22:0];
        r.right_w = ro[22:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // driver: present the head of the pending queue, drop it on handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_widths.push_back(predict_widths(pending_items.pop_front()));
            end
            if ((!s_axis_tvalid || s_axis_tready) &&
                pending_items.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)) begin
                // next head is the item to offer (pop above already done)
                if (pending_items.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_items[0].mode;
                    s_axis_tdata  <= {pending_items[0].right_w, pending_items[0].left_w,
                                      pending_items[0].station};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end else if (!s_axis_tvalid || s_axis_tready) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        width_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_widths.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, 0);
                end else begin
                    want = expected_widths.pop_front();
                    if (m_axis_tdata[22:0] !== want.left_w)
                        report_mismatch("left_width", m_axis_tdata[22:0], want.left_w);
                    if (m_axis_tdata[45:23] !== want.right_w)
                        report_mismatch("right_width", m_axis_tdata[45:23], want.right_w);
                    if (m_axis_tdata[47:46] !== want.status)
                        report_mismatch("status", m_axis_tdata[47:46], want.status);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 2_000_000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic lookup_item_t make_item(logic [1:0] m, longint s, longint l, longint r);
        lookup_item_t it;
        it.mode = m;
        it.station = s[31:0];
        it.left_w = l[23:0];
        it.right_w = r[23:0];
        return it;
    endfunction

    function automatic logic signed [23:0] rand_width();
        case ($urandom_range(5))
            0: return 24'sh7fffff;
            1: return 24'sh0;
            2: return 24'($urandom_range(255));
            default: return 24'($urandom_range(24'h7fffff));
        endcase
    endfunction

    // clear, well-formed table build, then queries and unused-mode items, with some broken appends
    task automatic queue_random_set(ref int budget);
        int n, q;
        longint st;
        pending_items.push_back(make_item(MODE_CLEAR, $urandom, $urandom, $urandom));
        budget--;
        n = ($urandom_range(9) == 0) ? MAX_POINTS + 2 : $urandom_range(1, 8);
        st = ($urandom_range(3) == 0) ? 0 : $urandom_range(1 << 20);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(11))
                0: pending_items.push_back(make_item(MODE_APPEND, $urandom,
                       {$urandom} | 32'h00800000, $urandom));
                1: pending_items.push_back(make_item(MODE_APPEND, st - $urandom_range(1),
                       rand_width(), rand_width()));
                2: pending_items.push_back(make_item(MODE_APPEND, st + 1,
                       rand_width(), -longint'($urandom_range(1, 8388608))));
                default: begin
                    st += ($urandom_range(3) == 0) ? $urandom_range(1, 4)
                                                   : $urandom_range(1, 1 << 26);
                    if (st > 32'h7fffffff) st = 32'h7fffffff;
                    pending_items.push_back(make_item(MODE_APPEND, st,
                                                      rand_width(), rand_width()));
                end
            endcase
            budget--;
        end
        q = $urandom_range(3, 10);
        for (int i = 0; i < q; i++) begin
            case ($urandom_range(7))
                0: pending_items.push_back(make_item(MODE_EVAL, $urandom, $urandom, $urandom));
                1: pending_items.push_back(make_item(MODE_UNUSED, $urandom, $urandom,
                                                     $urandom));
                default: pending_items.push_back(make_item(MODE_EVAL,
                             $urandom_range(32'(st + 16)), $urandom, $urandom));
            endcase
            budget--;
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_widths.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int budget;
        mismatch_count = 0;
        results_seen = 0;
        cycle_count = 0;
        bp_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_CLEAR;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, errors, extremes, clamps, interpolation, unused mode, full table
        pending_items.push_back(make_item(MODE_EVAL, 100, 0, 0));
        pending_items.push_back(make_item(MODE_APPEND, -1, 5, 5));
        pending_items.push_back(make_item(MODE_APPEND, 0, -8388608, 5));
        pending_items.push_back(make_item(MODE_APPEND, 0, 5, -1));
        pending_items.push_back(make_item(MODE_APPEND, 0, 8388607, 0));
        pending_items.push_back(make_item(MODE_APPEND, 0, 1, 1));
        pending_items.push_back(make_item(MODE_APPEND, 2147483647, 0, 8388607));
        pending_items.push_back(make_item(MODE_EVAL, -2147483648, 0, 0));
        pending_items.push_back(make_item(MODE_EVAL, 1073741823, 0, 0));
        pending_items.push_back(make_item(MODE_EVAL, 2147483647, 0, 0));
        pending_items.push_back(make_item(MODE_UNUSED, -1, -1, -1));
        pending_items.push_back(make_item(MODE_CLEAR, 0, 0, 0));
        for (int i = 0; i < MAX_POINTS + 1; i++)
            pending_items.push_back(make_item(MODE_APPEND, i * 256 + 256, i * 300, 4800 - i * 300));
        pending_items.push_back(make_item(MODE_EVAL, 4100, 0, 0));
        wait_drained();

        budget = 1050;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
                default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
            endcase
            for (int b = budget - 262; budget > b && budget > 0;) queue_random_set(budget);
            // hold the sender back until every outstanding result is in
            wait_drained();
        end

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (200) @(posedge i_clk);
        $display("covered %0d results over table clears, appends with every error and queries",
                 results_seen);
        $display("idle and stall phases: none, sender, receiver, both");
        if (mismatch_count == 0 && expected_widths.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: piecewise_linear_width_lookup.f
+incdir+rtl
rtl/plw_pkg.sv
rtl/plw_front.sv
rtl/plw_div.sv
rtl/plw_back.sv
rtl/piecewise_linear_width_lookup.sv
rtl/plw_checker.sv
tb/sv/tb_piecewise_linear_width_lookup.sv
